### sv/reed_solomon_systematic_encoder_defines.svh
// Assertion macros shared by the Reed-Solomon encoder checker.
// Expects i_clk and i_rst_n in the scope where a macro is used.
`ifndef REED_SOLOMON_SYSTEMATIC_ENCODER_DEFINES_SVH
`define REED_SOLOMON_SYSTEMATIC_ENCODER_DEFINES_SVH

// Check a consequence in the same cycle as its trigger.
`define RSE_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check a consequence in the cycle after its trigger.
`define RSE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### sv/rse_pkg.sv
// Shared types, register indexes and GF(2^m) arithmetic for the
// Reed-Solomon encoder. No dependencies.
`default_nettype none

package rse_pkg;

    localparam int SYMBOL_BITS    = 8;
    localparam int COUNT_BITS     = 8;
    localparam int PCOUNT_BITS    = 6;
    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = SYMBOL_BITS + 1;

    // Configuration register indexes
    localparam logic [CFG_INDEX_BITS-1:0] CFG_FIELD_POLY   = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_PARITY_COUNT = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_MSG_LENGTH   = 2'd2;

    typedef logic [SYMBOL_BITS-1:0] t_sym;

    typedef struct packed {
        t_sym message_symbol;
        logic final_symbol;
    } t_in_word;

    typedef struct packed {
        t_sym code_symbol;
        logic is_parity;
        logic end_of_codeword;
        logic length_error;
    } t_out_word;

    // Multiply by x and reduce with the low taps of the field polynomial.
    function automatic t_sym gf_xtime(input t_sym v, input t_sym taps);
        t_sym r;
        r = {v[SYMBOL_BITS-2:0], 1'b0};
        if (v[SYMBOL_BITS-1]) begin
            r = r ^ taps;
        end
        return r;
    endfunction

    // Shift-and-add product, most significant bit of b first.
    function automatic t_sym gf_mul(input t_sym a, input t_sym b, input t_sym taps);
        t_sym acc;
        acc = '0;
        for (int bit_i = SYMBOL_BITS - 1; bit_i >= 0; bit_i--) begin
            acc = gf_xtime(acc, taps);
            if (b[bit_i]) begin
                acc = acc ^ a;
            end
        end
        return acc;
    endfunction

endpackage

`default_nettype wire

### sv/rse_gen.sv
// Generator polynomial builder: multiplies in one root (x + alpha^i) per cycle.
// Depends on rse_pkg.
`default_nettype none

module rse_gen #(
    parameter int MAX_PARITY = 32,
    localparam int PCW = $clog2(MAX_PARITY + 1)
) (
    input  wire logic                                    i_clk,
    input  wire logic                                    i_rst_n,
    input  wire logic                                    i_restart,
    input  wire rse_pkg::t_sym                           i_field_taps,
    input  wire logic [PCW-1:0]                          i_parity_eff,
    output logic                                         o_busy,
    output logic [MAX_PARITY:0][rse_pkg::SYMBOL_BITS-1:0] o_coef
);
    import rse_pkg::*;

    logic           r_busy;
    logic [PCW-1:0] r_step;
    t_sym           r_root;
    t_sym           r_coef [MAX_PARITY+1];
    t_sym           n_coef [MAX_PARITY+1];

    // Multiply current g(x) by (x + root); all coefficients in parallel
    always_comb begin
        t_sym prev;
        prev = '0;
        for (int j = 0; j <= MAX_PARITY; j++) begin
            n_coef[j] = prev ^ gf_mul(r_coef[j], r_root, i_field_taps);
            prev      = r_coef[j];
        end
    end

    // Restart on reset or on a new polynomial or parity count; stop after P roots
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_restart) begin
            r_busy <= 1'b1;
            r_step <= '0;
            r_root <= t_sym'(2);
            for (int j = 0; j <= MAX_PARITY; j++) begin
                r_coef[j] <= (j == 0) ? t_sym'(1) : '0;
            end
        end else if (r_busy) begin
            if (r_step == i_parity_eff) begin
                r_busy <= 1'b0;
            end else begin
                r_step <= r_step + PCW'(1);
                r_root <= gf_xtime(r_root, i_field_taps);
                r_coef <= n_coef;
            end
        end
    end

    always_comb begin
        for (int j = 0; j <= MAX_PARITY; j++) begin
            o_coef[j] = r_coef[j];
        end
    end

    assign o_busy = r_busy;

endmodule

`default_nettype wire

### sv/rse_core.sv
// Encoder datapath: input register, parallel LFSR with length check,
// parity drain and output register. Depends on rse_pkg.
`default_nettype none

module rse_core #(
    parameter int MAX_PARITY = 32,
    localparam int PCW = $clog2(MAX_PARITY + 1),
    localparam int PW  = $clog2(MAX_PARITY)
) (
    input  wire logic                                    i_clk,
    input  wire logic                                    i_rst_n,
    input  wire logic                                    i_in_valid,
    output logic                                         o_in_ready,
    input  wire rse_pkg::t_in_word                       i_in_word,
    output logic                                         o_out_valid,
    input  wire logic                                    i_out_ready,
    output rse_pkg::t_out_word                           o_out_word,
    input  wire rse_pkg::t_sym                           i_field_taps,
    input  wire logic [PCW-1:0]                          i_parity_eff,
    input  wire logic [rse_pkg::COUNT_BITS-1:0]          i_msg_len,
    input  wire logic                                    i_gen_busy,
    input  wire logic [MAX_PARITY:0][rse_pkg::SYMBOL_BITS-1:0] i_coef
);
    import rse_pkg::*;

    logic                  r_in_valid;
    t_in_word              r_in;
    t_sym                  r_cell [MAX_PARITY];
    t_sym                  n_cell [MAX_PARITY];
    logic [COUNT_BITS-1:0] r_count;
    logic [PCW-1:0]        r_drain_left;
    logic                  r_out_valid;
    t_out_word             r_out;
    t_out_word             n_out;

    logic                  can_emit;
    logic                  draining;
    logic                  fire;
    logic                  len_err;
    logic                  last_parity;
    logic [PCW-1:0]        p_m1;
    logic [PCW-1:0]        d_m1;
    logic [PW-1:0]         top_idx;
    logic [PW-1:0]         drain_idx;
    logic [COUNT_BITS:0]   next_count;
    t_sym                  fb;

    // Handshake and stage control
    assign can_emit    = !r_out_valid || i_out_ready;
    assign draining    = (r_drain_left != '0);
    assign last_parity = (r_drain_left == PCW'(1));
    assign fire        = r_in_valid && !i_gen_busy && !draining && can_emit;
    assign o_in_ready  = !r_in_valid || fire;

    // Cell selection by effective parity count and drain position
    assign p_m1      = i_parity_eff - PCW'(1);
    assign d_m1      = r_drain_left - PCW'(1);
    assign top_idx   = p_m1[PW-1:0];
    assign drain_idx = d_m1[PW-1:0];

    // Length check against the configured message length
    assign next_count = {1'b0, r_count} + (COUNT_BITS + 1)'(1);
    assign len_err    = r_in.final_symbol ? (next_count != {1'b0, i_msg_len})
                                          : (next_count >= {1'b0, i_msg_len});

    // LFSR step: feedback times each generator coefficient, cells below P only
    assign fb = r_in.message_symbol ^ r_cell[top_idx];

    always_comb begin
        t_sym prev;
        prev = '0;
        for (int i = 0; i < MAX_PARITY; i++) begin
            if (PCW'(i) < i_parity_eff) begin
                n_cell[i] = prev ^ gf_mul(fb, i_coef[i], i_field_taps);
            end else begin
                n_cell[i] = r_cell[i];
            end
            prev = r_cell[i];
        end
    end

    // Select the next output word
    always_comb begin
        n_out = '0;
        priority if (draining) begin
            n_out.code_symbol     = r_cell[drain_idx];
            n_out.is_parity       = 1'b1;
            n_out.end_of_codeword = last_parity;
        end else if (len_err) begin
            n_out.end_of_codeword = 1'b1;
            n_out.length_error    = 1'b1;
        end else begin
            n_out.code_symbol = r_in.message_symbol;
        end
    end

    // Control state, LFSR cells and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
            r_drain_left <= '0;
            r_count      <= '0;
            for (int i = 0; i < MAX_PARITY; i++) begin
                r_cell[i] <= '0;
            end
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (can_emit) begin
                r_out_valid <= draining || fire;
            end
            if (draining && can_emit) begin
                r_drain_left <= r_drain_left - PCW'(1);
                if (last_parity) begin
                    for (int i = 0; i < MAX_PARITY; i++) begin
                        r_cell[i] <= '0;
                    end
                end
            end else if (fire) begin
                if (len_err) begin
                    r_count <= '0;
                    for (int i = 0; i < MAX_PARITY; i++) begin
                        r_cell[i] <= '0;
                    end
                end else begin
                    r_cell <= n_cell;
                    if (r_in.final_symbol) begin
                        r_count      <= '0;
                        r_drain_left <= i_parity_eff;
                    end else begin
                        r_count <= next_count[COUNT_BITS-1:0];
                    end
                end
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in_word;
        end
        if (can_emit && (draining || fire)) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

endmodule

`default_nettype wire

### sv/reed_solomon_systematic_encoder.sv
// Systematic Reed-Solomon encoder over GF(2^8). Message words pass through an
// input register and are echoed on the output in the cycle after the datapath
// takes them, so at full rate one word goes in and one comes out every cycle.
// The word marked final is followed by P parity words, one per cycle while the
// output is not stalled. During those cycles the datapath takes no new message
// word, and the input register can hold at most one waiting word, so a codeword
// of k message words gives k + P output words. After reset and after each write
// of field_polynomial or parity_count the generator is rebuilt, one root per
// cycle, and the datapath stalls until the rebuild is done. A length mismatch
// gives one flagged word instead of the echo and restarts the codeword.
// Depends on rse_pkg, rse_gen, rse_core.
`default_nettype none

module reed_solomon_systematic_encoder #(
    parameter int MAX_PARITY = 32
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_in_valid,
    output logic                                      o_in_ready,
    input  wire rse_pkg::t_in_word                    i_in_word,
    output logic                                      o_out_valid,
    input  wire logic                                 i_out_ready,
    output rse_pkg::t_out_word                        o_out_word,
    input  wire logic                                 i_cfg_valid,
    output logic                                      o_cfg_ready,
    input  wire logic [rse_pkg::CFG_INDEX_BITS-1:0]   i_cfg_index,
    input  wire logic [rse_pkg::CFG_DATA_BITS-1:0]    i_cfg_data
);
    import rse_pkg::*;

    localparam int PCW = $clog2(MAX_PARITY + 1);

    t_sym                   r_field_taps;
    logic [PCOUNT_BITS-1:0] r_parity_count;
    logic [COUNT_BITS-1:0]  r_msg_len;
    logic [PCW-1:0]         parity_eff;
    logic                   cfg_wr;
    logic                   gen_restart;
    logic                   gen_busy;
    logic [MAX_PARITY:0][SYMBOL_BITS-1:0] gen_coef;

    assign o_cfg_ready = 1'b1;
    assign cfg_wr      = i_cfg_valid && o_cfg_ready;
    assign gen_restart = cfg_wr && ((i_cfg_index == CFG_FIELD_POLY) ||
                                    (i_cfg_index == CFG_PARITY_COUNT));

    // Configuration registers; the x^m term of the polynomial is implied
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_field_taps   <= t_sym'(285);
            r_parity_count <= PCOUNT_BITS'(16);
            r_msg_len      <= COUNT_BITS'(239);
        end else if (cfg_wr) begin
            unique case (i_cfg_index)
                CFG_FIELD_POLY:   r_field_taps   <= i_cfg_data[SYMBOL_BITS-1:0];
                CFG_PARITY_COUNT: r_parity_count <= i_cfg_data[PCOUNT_BITS-1:0];
                CFG_MSG_LENGTH:   r_msg_len      <= i_cfg_data[COUNT_BITS-1:0];
                default: begin
                end
            endcase
        end
    end

    // Clamp parity count to 1 .. MAX_PARITY
    always_comb begin
        priority if (r_parity_count == '0) begin
            parity_eff = PCW'(1);
        end else if (int'(r_parity_count) > MAX_PARITY) begin
            parity_eff = PCW'(MAX_PARITY);
        end else begin
            parity_eff = PCW'(r_parity_count);
        end
    end

    rse_gen #(
        .MAX_PARITY (MAX_PARITY)
    ) u_gen (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_restart    (gen_restart),
        .i_field_taps (r_field_taps),
        .i_parity_eff (parity_eff),
        .o_busy       (gen_busy),
        .o_coef       (gen_coef)
    );

    rse_core #(
        .MAX_PARITY (MAX_PARITY)
    ) u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_in_word    (i_in_word),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_out_word   (o_out_word),
        .i_field_taps (r_field_taps),
        .i_parity_eff (parity_eff),
        .i_msg_len    (r_msg_len),
        .i_gen_busy   (gen_busy),
        .i_coef       (gen_coef)
    );

endmodule

`default_nettype wire

### sv/rse_checker.sv
// Port-level checks for the Reed-Solomon encoder, bound to the top level.
// Depends on rse_pkg and reed_solomon_systematic_encoder_defines.svh.
`default_nettype none

`include "reed_solomon_systematic_encoder_defines.svh"

module rse_checker (
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               o_out_valid,
    input wire logic               i_out_ready,
    input wire rse_pkg::t_out_word o_out_word
);

    // Hold a stalled output word
    `RSE_ASSERT_NEXT(a_out_hold, o_out_valid && !i_out_ready, o_out_valid && $stable(o_out_word), "output word changed while stalled")

    // Shape a length error word
    `RSE_ASSERT_SAME(a_err_shape, o_out_valid && o_out_word.length_error, o_out_word.end_of_codeword && !o_out_word.is_parity && (o_out_word.code_symbol == '0), "malformed length error word")

    // Mark end only on last parity or on an error
    `RSE_ASSERT_SAME(a_echo_end, o_out_valid && !o_out_word.is_parity, o_out_word.end_of_codeword == o_out_word.length_error, "echo word carries wrong end flag")

    // Stream parity words back to back until the last one
    `RSE_ASSERT_NEXT(a_parity_run, o_out_valid && i_out_ready && o_out_word.is_parity && !o_out_word.end_of_codeword, o_out_valid && o_out_word.is_parity, "parity run broken")

endmodule

bind reed_solomon_systematic_encoder rse_checker u_rse_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_word  (o_out_word)
);

`default_nettype wire
